[hw/rtl/lcc_pkg.sv]
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants of the line code codec: modes, item kinds,
// line levels and decode thresholds.
// ----------------------------------------------------------------------------
package lcc_pkg;

	localparam int SAMPLE_BITS = 8;
	// 1.0 is 1 << (SAMPLE_BITS-2); the thresholds sit at +-0.5
	localparam int HALF_THRESH = 1 << (SAMPLE_BITS - 3);

	typedef logic [1:0] mode_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [1:0] level_t;

	localparam mode_t MODE_NRZ        = 2'd0;
	localparam mode_t MODE_MANCHESTER = 2'd1;
	localparam mode_t MODE_NRZI       = 2'd2;
	localparam mode_t MODE_AMI        = 2'd3;

	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	localparam level_t LVL_ZERO = 2'sb00;
	localparam level_t LVL_POS  = 2'sb01;
	localparam level_t LVL_NEG  = 2'sb11;

	localparam sample_t THRESH_POS = sample_t'(HALF_THRESH);
	localparam sample_t THRESH_NEG = sample_t'(-HALF_THRESH);

	localparam int IN_DATA_BITS  = 1 + 2 * SAMPLE_BITS;
	localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = 5;
	localparam int OUT_TDATA_W   = 8;

	typedef struct packed {
		logic    req_type;
		logic    data_bit;
		sample_t first_half_sample;
		sample_t second_half_sample;
	} item_t;

	typedef struct packed {
		level_t first_half_level;
		level_t second_half_level;
		logic   decoded_bit;
	} result_t;

endpackage

[hw/rtl/lcc_codec.sv]
// ----------------------------------------------------------------------------
// lcc_codec
// Encode/decode logic for one item plus the NRZI and AMI running state.
// State advances only when the item is handed to the result register.
// ----------------------------------------------------------------------------
module lcc_codec (
	input  logic            clk,
	input  logic            arst_n,
	input  lcc_pkg::mode_t  code_mode,
	input  lcc_pkg::item_t  item,
	input  logic            fire,
	output lcc_pkg::result_t res
);
	import lcc_pkg::*;

	level_t  nrzi_tx_level_q;
	logic    ami_next_negative_q;
	level_t  nrzi_rx_prev_level_q;

	level_t  nrzi_tx_level_d;
	logic    ami_next_negative_d;
	level_t  nrzi_rx_prev_level_d;

	sample_t s1;
	sample_t s2;
	level_t  q_lvl;
	level_t  enc_lvl;

	assign s1 = item.first_half_sample;
	assign s2 = item.second_half_sample;

	// quantized second half, used by NRZI and AMI decode
	always_comb begin
		priority if (s2 > THRESH_POS) begin
			q_lvl = LVL_POS;
		end else if (s2 < THRESH_NEG) begin
			q_lvl = LVL_NEG;
		end else begin
			q_lvl = LVL_ZERO;
		end
	end

	always_comb begin
		res                  = '0;
		enc_lvl              = LVL_ZERO;
		nrzi_tx_level_d      = nrzi_tx_level_q;
		ami_next_negative_d  = ami_next_negative_q;
		nrzi_rx_prev_level_d = nrzi_rx_prev_level_q;
		if (item.req_type == REQ_ENCODE) begin
			unique case (code_mode)
				MODE_NRZ: begin
					enc_lvl = item.data_bit ? LVL_POS : LVL_ZERO;
					res.first_half_level  = enc_lvl;
					res.second_half_level = enc_lvl;
				end
				MODE_MANCHESTER: begin
					res.first_half_level  = item.data_bit ? LVL_POS : LVL_NEG;
					res.second_half_level = item.data_bit ? LVL_NEG : LVL_POS;
				end
				MODE_NRZI: begin
					// zero or high goes low on a mark, low goes high
					if (item.data_bit) begin
						nrzi_tx_level_d = nrzi_tx_level_q[1] ? LVL_POS : LVL_NEG;
					end
					res.first_half_level  = nrzi_tx_level_d;
					res.second_half_level = nrzi_tx_level_d;
				end
				default: begin
					if (item.data_bit) begin
						enc_lvl             = ami_next_negative_q ? LVL_NEG : LVL_POS;
						ami_next_negative_d = ~ami_next_negative_q;
					end
					res.first_half_level  = enc_lvl;
					res.second_half_level = enc_lvl;
				end
			endcase
		end else begin
			unique case (code_mode)
				MODE_NRZ: begin
					res.decoded_bit = (s2 > THRESH_POS);
				end
				MODE_MANCHESTER: begin
					res.decoded_bit = (s1 > THRESH_NEG) && (s2 < THRESH_POS);
				end
				MODE_NRZI: begin
					res.decoded_bit      = (q_lvl != nrzi_rx_prev_level_q);
					nrzi_rx_prev_level_d = q_lvl;
				end
				default: begin
					res.decoded_bit = (q_lvl != LVL_ZERO);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrzi_tx_level_q      <= LVL_ZERO;
			ami_next_negative_q  <= 1'b0;
			nrzi_rx_prev_level_q <= LVL_ZERO;
		end else if (fire) begin
			nrzi_tx_level_q      <= nrzi_tx_level_d;
			ami_next_negative_q  <= ami_next_negative_d;
			nrzi_rx_prev_level_q <= nrzi_rx_prev_level_d;
		end
	end

`ifndef SYNTH
	a_tx_level_legal: assert property (@(posedge clk) disable iff (!arst_n)
		nrzi_tx_level_q != 2'sb10)
		else $error("NRZI tx level holds an illegal code");

	a_rx_level_legal: assert property (@(posedge clk) disable iff (!arst_n)
		nrzi_rx_prev_level_q != 2'sb10)
		else $error("NRZI rx level holds an illegal code");

	a_ami_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.req_type == REQ_ENCODE && code_mode == MODE_AMI && item.data_bit)
		|=> ami_next_negative_q != $past(ami_next_negative_q))
		else $error("AMI polarity did not alternate on a mark");
`endif

endmodule

[hw/rtl/line_code_codec_unit.sv]
// ----------------------------------------------------------------------------
// line_code_codec_unit
// Per-bit NRZ / Manchester / NRZI / bipolar AMI line encoder and decoder.
// ----------------------------------------------------------------------------
// One item per clock while m_axis_tready keeps the result register moving. An
// accepted item lands in an input register, is coded by a short combinational
// path and is written to the result register, which drives m_axis_tvalid, once
// that register is empty or its result is being taken.
// The input side keeps accepting while a result waits, as long as the input
// register is empty or can move on. Encoder and decoder state (NRZI level,
// AMI polarity, last NRZI receive level) are separate and survive a write of
// code_mode; write code_mode only while the unit is empty.
module line_code_codec_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [1:0]                       cfg_wr_data,   // code_mode
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [0] data_bit, [8:1] first_half_sample, [16:9] second_half_sample
	input  logic [lcc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                             s_axis_tuser,  // [0] req_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [1:0] first_half_level, [3:2] second_half_level, [4] decoded_bit
	output logic [lcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import lcc_pkg::*;

	mode_t   code_mode_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_c;
	logic    advance;
	logic    s_fire;
	logic    fire;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign fire          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_mode_q <= MODE_NRZ;
		end else if (cfg_wr_en) begin
			code_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.req_type           <= s_axis_tuser;
			item_s1.data_bit           <= s_axis_tdata[0];
			item_s1.first_half_sample  <= s_axis_tdata[SAMPLE_BITS:1];
			item_s1.second_half_sample <= s_axis_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1];
		end
	end

	lcc_codec u_codec (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_mode (code_mode_q),
		.item      (item_s1),
		.fire      (fire),
		.res       (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - OUT_DATA_BITS)'(0), res_q.decoded_bit,
		res_q.second_half_level, res_q.first_half_level};

`ifndef SYNTH
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_axis_tvalid)
		else $error("item left the input register without reaching the output");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> valid_s1)
		else $error("accepted item missing from the input register");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while both registers are held");

	a_level_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'b10 && m_axis_tdata[3:2] != 2'b10))
		else $error("output level outside -1..1");
`endif

endmodule

[tb/line_code_codec_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_code_codec_checker
// Watches both stream ports and the code_mode write port of the line code
// codec. It keeps its own copy of the code and of the NRZI/AMI state, works
// out the expected result of every accepted item and compares each output
// item against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module line_code_codec_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [1:0]                      cfg_wr_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [lcc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [lcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                              fail_count,
	output int                              pending_count,
	output int                              checked_count
);
	import lcc_pkg::*;

	mode_t   code_sel;
	level_t  tx_level;
	logic    ami_neg_next;
	level_t  rx_prev_level;
	result_t line_results_q[$];

	// Codes one item with the current code and advances the coder state.
	function automatic result_t code_item(input logic req, input logic din,
		input sample_t s1, input sample_t s2);
		result_t r;
		level_t  q;
		r = '0;
		if (req == REQ_ENCODE) begin
			case (code_sel)
				MODE_NRZ: begin
					r.first_half_level  = din ? LVL_POS : LVL_ZERO;
					r.second_half_level = r.first_half_level;
				end
				MODE_MANCHESTER: begin
					r.first_half_level  = din ? LVL_POS : LVL_NEG;
					r.second_half_level = din ? LVL_NEG : LVL_POS;
				end
				MODE_NRZI: begin
					if (din)
						tx_level = (tx_level == LVL_NEG) ? LVL_POS : LVL_NEG;
					r.first_half_level  = tx_level;
					r.second_half_level = tx_level;
				end
				default: begin
					if (din) begin
						r.first_half_level  = ami_neg_next ? LVL_NEG : LVL_POS;
						r.second_half_level = r.first_half_level;
						ami_neg_next = ~ami_neg_next;
					end
				end
			endcase
		end else begin
			case (code_sel)
				MODE_NRZ:
					r.decoded_bit = (s2 > THRESH_POS);
				MODE_MANCHESTER:
					r.decoded_bit = (s1 > THRESH_NEG) && (s2 < THRESH_POS);
				MODE_NRZI: begin
					if (s2 > THRESH_POS)
						q = LVL_POS;
					else if (s2 < THRESH_NEG)
						q = LVL_NEG;
					else
						q = LVL_ZERO;
					r.decoded_bit = (q != rx_prev_level);
					rx_prev_level = q;
				end
				default:
					r.decoded_bit = (s2 > THRESH_POS) || (s2 < THRESH_NEG);
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		level_t  got_first;
		level_t  got_second;
		logic    got_bit;
		if (!arst_n) begin
			code_sel      = MODE_NRZ;
			tx_level      = LVL_ZERO;
			ami_neg_next  = 1'b0;
			rx_prev_level = LVL_ZERO;
			line_results_q.delete();
			fail_count    = 0;
			checked_count = 0;
			pending_count = 0;
		end else begin
			// retire the output first so a new item never matches its own result
			if (m_axis_tvalid && m_axis_tready) begin
				got_first  = level_t'(m_axis_tdata[1:0]);
				got_second = level_t'(m_axis_tdata[3:2]);
				got_bit    = m_axis_tdata[4];
				if (line_results_q.size() == 0) begin
					$error("result item with nothing expected: tdata %h", m_axis_tdata);
					fail_count++;
				end else begin
					exp_r = line_results_q.pop_front();
					checked_count++;
					if (got_first !== exp_r.first_half_level) begin
						$error("first_half_level: expected %0d, got %0d",
							exp_r.first_half_level, got_first);
						fail_count++;
					end
					if (got_second !== exp_r.second_half_level) begin
						$error("second_half_level: expected %0d, got %0d",
							exp_r.second_half_level, got_second);
						fail_count++;
					end
					if (got_bit !== exp_r.decoded_bit) begin
						$error("decoded_bit: expected %0d, got %0d",
							exp_r.decoded_bit, got_bit);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				line_results_q.push_back(code_item(s_axis_tuser, s_axis_tdata[0],
					sample_t'(s_axis_tdata[SAMPLE_BITS:1]),
					sample_t'(s_axis_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1])));
			if (cfg_wr_en)
				code_sel = mode_t'(cfg_wr_data);
			pending_count = line_results_q.size();
		end
	end

endmodule

[tb/line_code_codec_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_code_codec_unit_tb
// Stimulus and verdict for the line code codec. A directed pass walks every
// code through its edge cases, then random phases switch the code and send
// encode and decode items in bursts; most phases stall the receiver.
// ----------------------------------------------------------------------------
module line_code_codec_unit_tb;
	import lcc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;
	localparam int S_MAX       = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int S_MIN       = -(1 << (SAMPLE_BITS - 1));
	localparam int S_ONE       = 1 << (SAMPLE_BITS - 2);

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [1:0]             cfg_wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int fail_count;
	int pending_count;
	int checked_count;
	int cycle_count = 0;
	int item_count = 0;
	int mode_writes = 0;
	int stall_pct = 0;
	int ready_run = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	line_code_codec_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	line_code_codec_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	// receiver: runs of ready or stall with random length
	always @(posedge clk) begin
		if (ready_run == 0) begin
			ready_run     <= $urandom_range(1, 24);
			m_axis_tready <= (int'($urandom_range(0, 99)) >= stall_pct);
		end else begin
			ready_run <= ready_run - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// mix of uniform values, noisy line levels, threshold neighbors and extremes
	function automatic sample_t pick_sample();
		int v;
		case ($urandom_range(0, 3))
			0: v = int'($urandom_range(0, 2 * S_MAX + 1)) + S_MIN;
			1: v = (int'($urandom_range(0, 2)) - 1) * S_ONE
				+ int'($urandom_range(0, 80)) - 40;
			2: v = ($urandom_range(0, 1) ? HALF_THRESH : -HALF_THRESH)
				+ int'($urandom_range(0, 4)) - 2;
			default: v = $urandom_range(0, 1) ? S_MAX : S_MIN;
		endcase
		if (v > S_MAX)
			v = S_MAX;
		if (v < S_MIN)
			v = S_MIN;
		return sample_t'(v);
	endfunction

	// called at a rising edge; returns at the edge that takes the item
	task automatic send_item(input logic req, input logic din,
		input sample_t s1, input sample_t s2);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {{(IN_TDATA_W - IN_DATA_BITS){1'b0}}, s2, s1, din};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		item_count++;
	endtask

	task automatic send_enc(input logic din);
		send_item(REQ_ENCODE, din, pick_sample(), pick_sample());
	endtask

	task automatic send_dec(input int s1, input int s2);
		send_item(REQ_DECODE, 1'($urandom_range(0, 1)), sample_t'(s1), sample_t'(s2));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		@(posedge clk);
	endtask

	task automatic set_mode(input mode_t m);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_writes++;
	endtask

	initial begin
		int    burst_left;
		int    max_gap;
		int    gap;
		mode_t m;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// NRZ straight out of reset, then threshold edges
		send_enc(1'b0);
		send_enc(1'b1);
		send_dec(0, HALF_THRESH);
		send_dec(0, HALF_THRESH + 1);
		send_dec(S_MAX, S_MIN);
		send_dec(S_MIN, S_MAX);

		set_mode(MODE_MANCHESTER);
		send_enc(1'b1);
		send_enc(1'b0);
		send_dec(-HALF_THRESH, HALF_THRESH - 1);
		send_dec(-HALF_THRESH + 1, HALF_THRESH - 1);
		send_dec(S_MAX, S_MIN);
		send_dec(S_MIN, S_MAX);

		// NRZI: first 1 goes negative, a 0 holds the level
		set_mode(MODE_NRZI);
		send_enc(1'b1);
		send_enc(1'b1);
		send_enc(1'b0);
		send_enc(1'b1);
		send_dec(0, HALF_THRESH + 1);
		send_dec(0, HALF_THRESH + 1);
		send_dec(0, -HALF_THRESH - 1);
		send_dec(0, 0);

		// AMI: first mark positive, zeros leave polarity alone
		set_mode(MODE_AMI);
		send_enc(1'b1);
		send_enc(1'b0);
		send_enc(1'b1);
		send_enc(1'b1);
		send_dec(0, -HALF_THRESH - 1);
		send_dec(0, -HALF_THRESH);

		for (int ph = 0; ph < PHASES; ph++) begin
			m = (ph < 4) ? mode_t'(ph) : mode_t'($urandom_range(0, 3));
			set_mode(m);
			stall_pct  <= (ph % 3 == 0) ? 0 : $urandom_range(5, 70);
			max_gap    = (ph % 4 == 1) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 20);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 5 && n == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(0, 1))
					send_item(REQ_DECODE, 1'($urandom_range(0, 1)),
						pick_sample(), pick_sample());
				else
					send_enc(1'($urandom_range(0, 1)));
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap = $urandom_range(0, max_gap);
					if (gap > 0) begin
						s_axis_tvalid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
		end

		drain();
		repeat (4) @(posedge clk);

		$display("Sent %0d items under %0d code_mode writes, all four codes.",
			item_count, mode_writes);
		$display("Compared %0d result items, %0d mismatches.", checked_count, fail_count);
		if (fail_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
